// ----- design/prfpb_pkg.sv -----
// prfpb_pkg: shared constants and bundle types for the pair rest-frame position boost
// used by prfpb_isqrt, prfpb_muldiv and pair_rest_frame_position_boost
// depends on nothing
package prfpb_pkg;

  localparam int unsigned SQ_LAT    = 31;
  localparam int unsigned DIV_STEPS = 63;
  localparam int unsigned MD_LAT    = DIV_STEPS + 4;

  localparam logic [62:0] MAG_LIMIT = 63'h3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [30:0]        e;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } kin_t;

  typedef struct packed {
    logic v;
    logic inv;
    kin_t kin;
  } ka_t;

  typedef struct packed {
    logic               v;
    logic               inv;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [30:0]        e;
    logic [30:0]        pt;
    logic [30:0]        mt;
  } kb_t;

  typedef struct packed {
    logic signed [63:0] yy;
    logic signed [63:0] yx;
    logic signed [63:0] ze;
    logic signed [63:0] zz;
  } terms_t;

endpackage

// ----- design/pair_rest_frame_position_boost.sv -----
// pair_rest_frame_position_boost: boosts an emission point into the pair rest frame
// depends on prfpb_pkg, prfpb_delay, prfpb_isqrt, prfpb_muldiv
//
// channel   ports                                  handshake
// request   start_i, busy_o, first_*, second_*, point_*   taken when start_i && !busy_o
// result    done_o, boosted_*_o, invalid_o         one-cycle strobe on done_o
//
// one request per cycle, every cycle; busy_o stays low
// pipeline: 4 front stages, 31 square-root stages, two 67-stage divide units, output
// the divide units (one quotient bit per stage) set most of the latency
// reset clears all valid bits at once; results cannot be held off downstream
module pair_rest_frame_position_boost #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [WORD_BITS-1:0] first_px_i,
  input  logic signed [WORD_BITS-1:0] first_py_i,
  input  logic signed [WORD_BITS-1:0] first_pz_i,
  input  logic [WORD_BITS-2:0]        first_energy_i,
  input  logic signed [WORD_BITS-1:0] second_px_i,
  input  logic signed [WORD_BITS-1:0] second_py_i,
  input  logic signed [WORD_BITS-1:0] second_pz_i,
  input  logic [WORD_BITS-2:0]        second_energy_i,
  input  logic signed [WORD_BITS-1:0] point_x_i,
  input  logic signed [WORD_BITS-1:0] point_y_i,
  input  logic signed [WORD_BITS-1:0] point_z_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] boosted_x_o,
  output logic signed [WORD_BITS-1:0] boosted_y_o,
  output logic signed [WORD_BITS-1:0] boosted_z_o,
  output logic signed [WORD_BITS-1:0] boosted_time_o,
  output logic                        invalid_o
);
  import prfpb_pkg::*;

  localparam int unsigned PRE_SHIFT = (WORD_BITS > 31) ? WORD_BITS - 31 : 0;
  localparam int unsigned PIPE_LAT  = 4 + SQ_LAT + 2 * MD_LAT + 1;
  localparam logic signed [63:0] OUT_HI = $signed((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic signed [63:0] OUT_LO = -OUT_HI - 64'sd1;

  function automatic logic signed [31:0] pair_sum(logic signed [WORD_BITS-1:0] a,
                                                  logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = (WORD_BITS+1)'(a >>> 1) + (WORD_BITS+1)'(b >>> 1);
    return 32'(s >>> PRE_SHIFT);
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat(logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > OUT_HI)      c = OUT_HI;
    else if (v < OUT_LO) c = OUT_LO;
    else                 c = v;
    return c[WORD_BITS-1:0];
  endfunction

  logic               accept;
  logic               v1_q, v2_q, v3_q, v4_q;
  kin_t               k1_q, k2_q, k3_q, k4_q;
  logic [WORD_BITS-1:0] esum;
  logic signed [63:0] pxx_q, pyy_q, pzz_q;
  logic [61:0]        ee_q;
  logic signed [63:0] pt2_q, mt2_q, pt2_4_q, mt2_4_q, m2_4_q, m2_d;
  logic               inv4_q;
  ka_t                ka_in, ka_out;
  kb_t                kb_in, kb_out;
  logic [30:0]        pt_w, mt_w, m_w;
  logic signed [63:0] o_w, l_w;
  terms_t             tm_in, tm_out;
  logic signed [63:0] ox_w, oy_w, lz_w, le_w;
  logic [1:0]         vi_w;
  logic               done_q, inv_q;
  logic signed [WORD_BITS-1:0] bx_q, by_q, bz_q, bt_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign esum   = {1'b0, first_energy_i >> 1} + {1'b0, second_energy_i >> 1};
  assign m2_d   = mt2_q - pt2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= vi_w[1];
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q.px <= pair_sum(first_px_i, second_px_i);
    k1_q.py <= pair_sum(first_py_i, second_py_i);
    k1_q.pz <= pair_sum(first_pz_i, second_pz_i);
    k1_q.e  <= 31'(esum >> PRE_SHIFT);
    k1_q.x  <= 64'(point_x_i);
    k1_q.y  <= 64'(point_y_i);
    k1_q.z  <= 64'(point_z_i);
    k2_q    <= k1_q;
    pxx_q   <= k1_q.px * k1_q.px;
    pyy_q   <= k1_q.py * k1_q.py;
    pzz_q   <= k1_q.pz * k1_q.pz;
    ee_q    <= k1_q.e * k1_q.e;
    k3_q    <= k2_q;
    pt2_q   <= pxx_q + pyy_q;
    mt2_q   <= $signed({2'b00, ee_q}) - pzz_q;
    k4_q    <= k3_q;
    pt2_4_q <= pt2_q;
    mt2_4_q <= mt2_q;
    m2_4_q  <= m2_d;
    inv4_q  <= (pt2_q == 64'sd0) || (m2_d <= 64'sd0);
  end

  always_comb begin
    ka_in.v   = v4_q;
    ka_in.inv = inv4_q;
    ka_in.kin = k4_q;
  end

  prfpb_delay #(.WIDTH($bits(ka_t)), .DEPTH(SQ_LAT)) u_dly_a (
    .clk_i, .rst_ni, .d_i(ka_in), .q_o(ka_out)
  );

  prfpb_isqrt u_sq_pt (.clk_i, .rad_i(pt2_4_q[61:0]), .root_o(pt_w));
  prfpb_isqrt u_sq_mt (.clk_i, .rad_i(mt2_4_q[61:0]), .root_o(mt_w));
  prfpb_isqrt u_sq_m  (.clk_i, .rad_i(m2_4_q[61:0]),  .root_o(m_w));

  prfpb_muldiv u_md_o  (.clk_i, .a_i(ka_out.kin.x), .b_i($signed({1'b0, mt_w})),
                        .c_i(m_w), .y_o(o_w));
  prfpb_muldiv u_md_l  (.clk_i, .a_i(ka_out.kin.x), .b_i($signed({1'b0, pt_w})),
                        .c_i(m_w), .y_o(l_w));
  prfpb_muldiv u_md_ze (.clk_i, .a_i(ka_out.kin.z), .b_i($signed({1'b0, ka_out.kin.e})),
                        .c_i(mt_w), .y_o(tm_in.ze));
  prfpb_muldiv u_md_zz (.clk_i, .a_i(ka_out.kin.z), .b_i(ka_out.kin.pz),
                        .c_i(mt_w), .y_o(tm_in.zz));
  prfpb_muldiv u_md_yy (.clk_i, .a_i(ka_out.kin.y), .b_i(ka_out.kin.py),
                        .c_i(pt_w), .y_o(tm_in.yy));
  prfpb_muldiv u_md_yx (.clk_i, .a_i(ka_out.kin.y), .b_i(ka_out.kin.px),
                        .c_i(pt_w), .y_o(tm_in.yx));

  always_comb begin
    kb_in.v   = ka_out.v;
    kb_in.inv = ka_out.inv;
    kb_in.px  = ka_out.kin.px;
    kb_in.py  = ka_out.kin.py;
    kb_in.pz  = ka_out.kin.pz;
    kb_in.e   = ka_out.kin.e;
    kb_in.pt  = pt_w;
    kb_in.mt  = mt_w;
  end

  prfpb_delay #(.WIDTH($bits(kb_t)), .DEPTH(MD_LAT)) u_dly_b (
    .clk_i, .rst_ni, .d_i(kb_in), .q_o(kb_out)
  );

  prfpb_delay #(.WIDTH($bits(terms_t)), .DEPTH(MD_LAT)) u_dly_t (
    .clk_i, .rst_ni, .d_i(tm_in), .q_o(tm_out)
  );

  prfpb_delay #(.WIDTH(2), .DEPTH(MD_LAT)) u_dly_v (
    .clk_i, .rst_ni, .d_i({kb_out.v, kb_out.inv}), .q_o(vi_w)
  );

  prfpb_muldiv u_md_ox (.clk_i, .a_i(o_w), .b_i(kb_out.px), .c_i(kb_out.pt), .y_o(ox_w));
  prfpb_muldiv u_md_oy (.clk_i, .a_i(o_w), .b_i(kb_out.py), .c_i(kb_out.pt), .y_o(oy_w));
  prfpb_muldiv u_md_lz (.clk_i, .a_i(l_w), .b_i(kb_out.pz), .c_i(kb_out.mt), .y_o(lz_w));
  prfpb_muldiv u_md_le (.clk_i, .a_i(l_w), .b_i($signed({1'b0, kb_out.e})),
                        .c_i(kb_out.mt), .y_o(le_w));

  always_ff @(posedge clk_i) begin
    inv_q <= vi_w[0];
    if (vi_w[0]) begin
      bx_q <= '0;
      by_q <= '0;
      bz_q <= '0;
      bt_q <= '0;
    end else begin
      bx_q <= sat(ox_w - tm_out.yy);
      by_q <= sat(oy_w + tm_out.yx);
      bz_q <= sat(tm_out.ze + lz_w);
      bt_q <= sat(le_w + tm_out.zz);
    end
  end

  assign done_o         = done_q;
  assign invalid_o      = inv_q;
  assign boosted_x_o    = bx_q;
  assign boosted_y_o    = by_q;
  assign boosted_z_o    = bz_q;
  assign boosted_time_o = bt_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##PIPE_LAT done_o) else $error("result missing after request");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##PIPE_LAT !done_o) else $error("result without request");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && invalid_o |-> boosted_x_o == '0 && boosted_y_o == '0 &&
                            boosted_z_o == '0 && boosted_time_o == '0)
    else $error("invalid pair with nonzero position");

endmodule

// ----- design/prfpb_delay.sv -----
// prfpb_delay: fixed-depth shift register that keeps side data aligned with the math units
// standalone, no package
module prfpb_delay #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sh_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) sh_q[i] <= '0;
    end else begin
      sh_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) sh_q[i] <= sh_q[i-1];
    end
  end

  assign q_o = sh_q[DEPTH-1];

endmodule

// ----- design/prfpb_isqrt.sv -----
// prfpb_isqrt: pipelined floor square root, one root bit per stage
// depends on prfpb_pkg
module prfpb_isqrt (
  input  logic        clk_i,
  input  logic [61:0] rad_i,
  output logic [30:0] root_o
);
  import prfpb_pkg::*;

  logic [61:0] v_q [SQ_LAT];
  logic [32:0] r_q [SQ_LAT];
  logic [30:0] q_q [SQ_LAT];
  logic [61:0] v_d [SQ_LAT];
  logic [32:0] r_d [SQ_LAT];
  logic [30:0] q_d [SQ_LAT];

  always_comb begin
    logic [61:0] vi;
    logic [32:0] ri;
    logic [30:0] qi;
    logic [34:0] rn;
    logic [34:0] t;
    for (int j = 0; j < SQ_LAT; j++) begin
      if (j == 0) begin
        vi = rad_i;
        ri = '0;
        qi = '0;
      end else begin
        vi = v_q[j-1];
        ri = r_q[j-1];
        qi = q_q[j-1];
      end
      rn = {ri, vi[61:60]};
      t  = {2'b00, qi, 2'b01};
      v_d[j] = {vi[59:0], 2'b00};
      if (rn >= t) begin
        r_d[j] = 33'(rn - t);
        q_d[j] = {qi[29:0], 1'b1};
      end else begin
        r_d[j] = rn[32:0];
        q_d[j] = {qi[29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < SQ_LAT; j++) begin
      v_q[j] <= v_d[j];
      r_q[j] <= r_d[j];
      q_q[j] <= q_d[j];
    end
  end

  assign root_o = q_q[SQ_LAT-1];

endmodule

// ----- design/prfpb_muldiv.sv -----
// prfpb_muldiv: pipelined a*b/c, rounded half away from zero, magnitude saturated
// split multiply, then one quotient bit per stage; depends on prfpb_pkg
module prfpb_muldiv (
  input  logic               clk_i,
  input  logic signed [63:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic [30:0]        c_i,
  output logic signed [63:0] y_o
);
  import prfpb_pkg::*;

  typedef struct packed {
    logic [30:0] rem;
    logic [62:0] num;
    logic [62:0] quo;
    logic [30:0] c;
    logic        neg;
    logic        ovf;
  } div_t;

  logic [63:0] ma_q;
  logic [31:0] mb_q;
  logic [30:0] c1_q;
  logic        neg1_q;
  logic [63:0] hi_q;
  logic [63:0] lo_q;
  logic [30:0] c2_q;
  logic        neg2_q;
  logic [95:0] n_d;
  div_t        st_d;
  div_t        st_q;
  div_t        dv_d [DIV_STEPS];
  div_t        dv_q [DIV_STEPS];
  logic [62:0] mag_d;
  logic signed [63:0] y_q;

  always_comb begin
    n_d = {hi_q, 32'd0} + {32'd0, lo_q} + 96'(c2_q >> 1);
    st_d.rem = n_d[93:63];
    st_d.num = n_d[62:0];
    st_d.quo = '0;
    st_d.c   = c2_q;
    st_d.neg = neg2_q;
    st_d.ovf = (n_d[95:63] >= {2'b00, c2_q});
  end

  always_comb begin
    div_t        di;
    logic [31:0] t;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) di = st_q;
      else        di = dv_q[j-1];
      t = {di.rem, di.num[62]};
      dv_d[j] = di;
      dv_d[j].num = {di.num[61:0], 1'b0};
      if (t >= {1'b0, di.c}) begin
        dv_d[j].rem = 31'(t - {1'b0, di.c});
        dv_d[j].quo = {di.quo[61:0], 1'b1};
      end else begin
        dv_d[j].rem = t[30:0];
        dv_d[j].quo = {di.quo[61:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (dv_q[DIV_STEPS-1].ovf || dv_q[DIV_STEPS-1].quo > MAG_LIMIT) begin
      mag_d = MAG_LIMIT;
    end else begin
      mag_d = dv_q[DIV_STEPS-1].quo;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
    mb_q   <= b_i[31] ? 32'(-b_i) : 32'(b_i);
    c1_q   <= c_i;
    neg1_q <= a_i[63] ^ b_i[31];
    hi_q   <= ma_q[63:32] * mb_q;
    lo_q   <= ma_q[31:0] * mb_q;
    c2_q   <= c1_q;
    neg2_q <= neg1_q;
    st_q   <= st_d;
    for (int j = 0; j < DIV_STEPS; j++) dv_q[j] <= dv_d[j];
    y_q    <= dv_q[DIV_STEPS-1].neg ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});
  end

  assign y_o = y_q;

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for pair_rest_frame_position_boost
// predicts each boosted four-position and invalid flag in-bench and checks every done_o strobe
// depends on design/prfpb_pkg.sv and design/pair_rest_frame_position_boost.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned WB = 32;
  localparam int unsigned LATENCY = 170;
  localparam logic [63:0] SAT_MAG = {1'b0, prfpb_pkg::MAG_LIMIT};

  typedef struct {
    logic signed [WB-1:0] p1x, p1y, p1z;
    logic [WB-2:0]        e1;
    logic signed [WB-1:0] p2x, p2y, p2z;
    logic [WB-2:0]        e2;
    logic signed [WB-1:0] x, y, z;
  } pair_req_t;

  typedef struct {
    logic signed [WB-1:0] bx, by, bz, bt;
    logic                 inv;
  } boost_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [WB-1:0] first_px_i = '0, first_py_i = '0, first_pz_i = '0;
  logic [WB-2:0]        first_energy_i = '0;
  logic signed [WB-1:0] second_px_i = '0, second_py_i = '0, second_pz_i = '0;
  logic [WB-2:0]        second_energy_i = '0;
  logic signed [WB-1:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic done_o;
  logic signed [WB-1:0] boosted_x_o, boosted_y_o, boosted_z_o, boosted_time_o;
  logic invalid_o;

  boost_res_t pending_boosts[$];
  int unsigned n_errors = 0;
  bit no_idle = 1'b0;

  pair_rest_frame_position_boost #(.WORD_BITS(WB)) uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // a*b/c rounded half away from zero, magnitude saturated
  function automatic longint scale_div(longint a, longint b, longint c);
    logic [127:0] ma, mb, q;
    logic [63:0]  mag;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    q = (ma * mb + 128'(c / 2)) / 128'(c);
    mag = (q > 128'(SAT_MAG)) ? SAT_MAG : q[63:0];
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [WB-1:0] sat_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[WB-1:0];
  endfunction

  function automatic longint half_sum(logic signed [WB-1:0] a, logic signed [WB-1:0] b);
    longint sa, sb;
    sa = a;
    sb = b;
    return ((sa >>> 1) + (sb >>> 1)) >>> 1;
  endfunction

  function automatic boost_res_t predict_boost(pair_req_t r);
    boost_res_t res;
    longint px, py, pz, e, x, y, z, pt2, mt2, m2, pt, mt, m, o, l;
    px = half_sum(r.p1x, r.p2x);
    py = half_sum(r.p1y, r.p2y);
    pz = half_sum(r.p1z, r.p2z);
    e = ((longint'(r.e1) >> 1) + (longint'(r.e2) >> 1)) >> 1;
    x = r.x;
    y = r.y;
    z = r.z;
    pt2 = px * px + py * py;
    mt2 = e * e - pz * pz;
    m2 = mt2 - pt2;
    res = '{default: '0};
    if (pt2 == 0 || m2 <= 0) begin
      res.inv = 1'b1;
      return res;
    end
    pt = isqrt64(pt2);
    mt = isqrt64(mt2);
    m = isqrt64(m2);
    o = scale_div(x, mt, m);
    l = scale_div(x, pt, m);
    res.bx = sat_word(scale_div(o, px, pt) - scale_div(y, py, pt));
    res.by = sat_word(scale_div(o, py, pt) + scale_div(y, px, pt));
    res.bz = sat_word(scale_div(z, e, mt) + scale_div(l, pz, mt));
    res.bt = sat_word(scale_div(l, e, mt) + scale_div(z, pz, mt));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk_i) begin
    boost_res_t w;
    if (rst_ni && done_o) begin
      if (pending_boosts.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_boosts.pop_front();
        if (boosted_x_o !== w.bx) report_mismatch("boosted_x", boosted_x_o, w.bx);
        if (boosted_y_o !== w.by) report_mismatch("boosted_y", boosted_y_o, w.by);
        if (boosted_z_o !== w.bz) report_mismatch("boosted_z", boosted_z_o, w.bz);
        if (boosted_time_o !== w.bt) report_mismatch("boosted_time", boosted_time_o, w.bt);
        if (invalid_o !== w.inv) report_mismatch("invalid", invalid_o, w.inv);
      end
    end
  end

  task automatic idle_cycles(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_pair(pair_req_t r);
    start_i <= 1'b1;
    first_px_i <= r.p1x;
    first_py_i <= r.p1y;
    first_pz_i <= r.p1z;
    first_energy_i <= r.e1;
    second_px_i <= r.p2x;
    second_py_i <= r.p2y;
    second_pz_i <= r.p2z;
    second_energy_i <= r.e2;
    point_x_i <= r.x;
    point_y_i <= r.y;
    point_z_i <= r.z;
    do @(posedge clk_i); while (busy_o);
    pending_boosts.push_back(predict_boost(r));
    if (!no_idle && $urandom_range(99) < 35) idle_cycles(1);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_boosts.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic signed [WB-1:0] rand_signed(int unsigned bits);
    logic signed [WB-1:0] v;
    v = $urandom() & ((bits >= 31) ? 32'h7FFF_FFFF : ((32'd1 << bits) - 1));
    return ($urandom_range(1)) ? -v : v;
  endfunction

  function automatic pair_req_t noise_pair();
    pair_req_t r;
    r.p1x = $urandom(); r.p1y = $urandom(); r.p1z = $urandom(); r.e1 = 31'($urandom());
    r.p2x = $urandom(); r.p2y = $urandom(); r.p2z = $urandom(); r.e2 = 31'($urandom());
    r.x = $urandom(); r.y = $urandom(); r.z = $urandom();
    return r;
  endfunction

  // energies above the momentum sums so the pair mass squared stays positive
  function automatic pair_req_t physical_pair();
    pair_req_t r;
    int unsigned w;
    longint s1, s2;
    w = $urandom_range(3, 28);
    r.p1x = rand_signed(w); r.p1y = rand_signed(w); r.p1z = rand_signed(w);
    r.p2x = rand_signed(w); r.p2y = rand_signed(w); r.p2z = rand_signed(w);
    s1 = longint'(r.p1x < 0 ? -r.p1x : r.p1x) + (r.p1y < 0 ? -r.p1y : r.p1y)
       + (r.p1z < 0 ? -r.p1z : r.p1z) + $urandom_range(0, 1 << w) + 8;
    s2 = longint'(r.p2x < 0 ? -r.p2x : r.p2x) + (r.p2y < 0 ? -r.p2y : r.p2y)
       + (r.p2z < 0 ? -r.p2z : r.p2z) + $urandom_range(0, 1 << w) + 8;
    r.e1 = (s1 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : s1[30:0];
    r.e2 = (s2 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : s2[30:0];
    w = $urandom_range(4, 31);
    r.x = rand_signed(w); r.y = rand_signed(w); r.z = rand_signed(w);
    return r;
  endfunction

  task automatic test_directed();
    pair_req_t r;
    // typical pair, unit momenta
    r = '{32'sh10000, 32'sh20000, 32'sh30000, 31'h50000, 32'sh10000, -32'sh10000, 32'sh0,
          31'h40000, 32'sh8000, -32'sh18000, 32'sh30000};
    send_pair(r);
    // zero transverse momentum
    r = '{32'sh0, 32'sh0, 32'sh30000, 31'h50000, 32'sh0, 32'sh0, 32'sh10000, 31'h40000,
          32'sh10000, 32'sh10000, 32'sh10000};
    send_pair(r);
    // massless pair: mass squared not positive
    r = '{32'sh40000, 32'sh0, 32'sh0, 31'h40000, 32'sh40000, 32'sh0, 32'sh0, 31'h40000,
          32'sh10000, 32'sh10000, 32'sh10000};
    send_pair(r);
    // tiny inputs: the energy vanishes in the prescale, leaving a non-positive mass squared
    r = '{32'sh1, -32'sh1, 32'sh0, 31'h3, 32'sh1, 32'sh0, 32'sh0, 31'h1, 32'sh1, 32'sh1, 32'sh1};
    send_pair(r);
    // all extremes
    r = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF};
    send_pair(r);
    r = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h0, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 31'h0, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000};
    send_pair(r);
    // max energy, small transverse momentum, extreme points: saturating outputs
    r = '{32'sh4, 32'sh0, 32'sh0, 31'h7FFF_FFFF, 32'sh0, 32'sh4, 32'sh7FFF_FFF0, 31'h7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send_pair(r);
    r = '{-32'sh8, 32'sh8, -32'sh7000_0000, 31'h7FFF_FFFF, 32'sh0, 32'sh0, -32'sh7000_0000,
          31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_pair(r);
    // zero point
    r = '{32'sh20000, 32'sh10000, -32'sh10000, 31'h60000, -32'sh10000, 32'sh20000, 32'sh10000,
          31'h50000, 32'sh0, 32'sh0, 32'sh0};
    send_pair(r);
    // negative energy bit patterns cannot exist; large unbalanced pair
    r = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh0, 31'h7FFF_FFFF, -32'sh1, 32'sh1, -32'sh1};
    send_pair(r);
    for (int i = 0; i < 10; i++) send_pair(physical_pair());
  endtask

  task automatic test_random_pairs(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      no_idle = (i >= n / 3) && (i < n / 3 + 150);
      send_pair(($urandom_range(99) < 80) ? physical_pair() : noise_pair());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pair(noise_pair());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random_pairs(700);
    wait_drained();
    test_random_pairs(600);
    test_noise(280);
    wait_drained();
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
